// ----- hdl/text_cursor_scroll_engine_top_defines.svh -----
// Assertion macros shared by the text cursor scroll engine RTL.
// Included by files that carry concurrent assertions; expects clock and reset in scope.
`ifndef TEXT_CURSOR_SCROLL_ENGINE_TOP_DEFINES_SVH
`define TEXT_CURSOR_SCROLL_ENGINE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define TCSE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Condition in one cycle implies consequence in the next.
`define TCSE_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tcse_pkg.sv -----
// Package for the text cursor scroll engine: constants, op codes and queue entry type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcse_pkg;

   localparam int SCREEN_WIDTH_DEF = 128;
   localparam int VIEW_PAGES_DEF   = 8;
   localparam int MEMORY_PAGES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF  = 2;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_FIRST = 8'h20;
   localparam logic [7:0] CHAR_END   = 8'h7F;

   localparam logic [7:0] GLYPH_WIDTH = 8'd8;
   localparam logic [4:0] LINE_PAGES  = 5'd2;

   localparam logic CMD_DRAW    = 1'b0;
   localparam logic CMD_SET_ROW = 1'b1;

   localparam logic REG_WRAP_ENABLE = 1'b0;

   typedef enum logic [1:0] {
      OP_RETURN,
      OP_NEWLINE,
      OP_GLYPH
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [6:0] glyph;
   } entry_type;

endpackage

`default_nettype wire

// ----- hdl/tcse_front.sv -----
// Front end: takes character transfers, classifies them and pushes ops into the queue.
// Depends on tcse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcse_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [7:0]          req_char_code,
   output logic                     push_valid,
   output tcse_pkg::entry_type      push_entry,
   input  wire logic                push_ready
);
   import tcse_pkg::*;

   logic      fr_valid_ff, fr_valid_in;
   entry_type fr_entry_ff, fr_entry_in;
   logic      accept;
   logic      keep;
   entry_type cls;

   always_comb begin
      cls.glyph = 7'(req_char_code - CHAR_FIRST);
      cls.op    = OP_GLYPH;
      keep      = 1'b1;
      if (req_char_code == CHAR_CR) begin
         cls.op = OP_RETURN;
      end else if (req_char_code == CHAR_LF) begin
         cls.op = OP_NEWLINE;
      end else if (req_char_code < CHAR_FIRST || req_char_code >= CHAR_END) begin
         keep = 1'b0;  // unprintable: accepted and dropped
      end
   end

   assign req_stall  = fr_valid_ff && !push_ready;
   assign accept     = req_valid && !req_stall;
   assign push_valid = fr_valid_ff;
   assign push_entry = fr_entry_ff;

   always_comb begin
      fr_valid_in = fr_valid_ff && !push_ready;
      fr_entry_in = fr_entry_ff;
      if (accept) begin
         fr_valid_in = keep;
         fr_entry_in = cls;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fr_entry_ff <= fr_entry_in;
   end

endmodule

`default_nettype wire

// ----- hdl/tcse_queue.sv -----
// Short op queue between front and back end, register based.
// Depends on tcse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcse_queue #(
   parameter int DEPTH = tcse_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   input  wire tcse_pkg::entry_type push_entry,
   output logic                     push_ready,
   output logic                     pop_valid,
   output tcse_pkg::entry_type      pop_entry,
   input  wire logic                pop
);
   import tcse_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != FULL_CNT);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/tcse_back.sv -----
// Back end: holds cursor and scroll state, executes queued ops and drives the result register.
// Depends on tcse_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "text_cursor_scroll_engine_top_defines.svh"

module tcse_back #(
   parameter int SCREEN_WIDTH = tcse_pkg::SCREEN_WIDTH_DEF,
   parameter int VIEW_PAGES   = tcse_pkg::VIEW_PAGES_DEF,
   parameter int MEMORY_PAGES = tcse_pkg::MEMORY_PAGES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wrap_enable,
   input  wire logic                pop_valid,
   input  wire tcse_pkg::entry_type pop_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_command_kind,
   output logic [7:0]               rsp_column_px,
   output logic [3:0]               rsp_page_row,
   output logic [6:0]               rsp_glyph_index,
   output logic [6:0]               rsp_display_row,
   output logic                     rsp_last_result
);
   import tcse_pkg::*;

   localparam logic [7:0] EDGE_PX  = 8'(SCREEN_WIDTH);
   // view size pre-reduced so start + view needs only one subtract
   localparam logic [4:0] VIEW_5   = 5'(VIEW_PAGES % MEMORY_PAGES);
   localparam logic [4:0] MEM_5    = 5'(MEMORY_PAGES);
   localparam logic [3:0] MEM_4    = 4'(MEMORY_PAGES);

   logic [7:0] column_ff, column_in;
   logic [3:0] page_ff, page_in;
   logic [3:0] start_ff, start_in;
   logic       pend_ff, pend_in;
   logic [6:0] pend_row_ff, pend_row_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] col_out_ff, col_out_in;
   logic [3:0] page_out_ff, page_out_in;
   logic [6:0] glyph_out_ff, glyph_out_in;
   logic [6:0] row_out_ff, row_out_in;
   logic       last_ff, last_in;

   // new-line arithmetic, single conditional subtract per modulo
   logic [4:0] page_sum, lim_sum, limit, start_sum;
   logic [4:0] page_wrapped, start_wrapped;
   logic       scroll;
   logic [6:0] scroll_row;
   logic [7:0] column_adv;
   logic       out_free, drop, wrap_nl;

   always_comb begin
      page_sum      = {1'b0, page_ff} + LINE_PAGES;
      lim_sum       = {1'b0, start_ff} + VIEW_5;
      limit         = (lim_sum >= MEM_5) ? lim_sum - MEM_5 : lim_sum;
      start_sum     = {1'b0, start_ff} + LINE_PAGES;
      start_wrapped = (start_sum >= MEM_5) ? start_sum - MEM_5 : start_sum;
      page_wrapped  = (page_sum >= MEM_5) ? page_sum - MEM_5 : page_sum;
      scroll        = (page_sum >= limit);
      scroll_row    = {start_wrapped[3:0], 3'b000};
      column_adv    = column_ff + GLYPH_WIDTH;
      drop          = (column_ff >= EDGE_PX) && !wrap_enable;
      wrap_nl       = (column_adv >= EDGE_PX) && wrap_enable;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      column_in    = column_ff;
      page_in      = page_ff;
      start_in     = start_ff;
      pend_in      = pend_ff;
      pend_row_in  = pend_row_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      col_out_in   = col_out_ff;
      page_out_in  = page_out_ff;
      glyph_out_in = glyph_out_ff;
      row_out_in   = row_out_ff;
      last_in      = last_ff;

      if (pend_ff) begin
         // second command of a draw that wrapped and scrolled
         if (out_free) begin
            pend_in      = 1'b0;
            rsp_valid_in = 1'b1;
            kind_in      = CMD_SET_ROW;
            col_out_in   = '0;
            page_out_in  = '0;
            glyph_out_in = '0;
            row_out_in   = pend_row_ff;
            last_in      = 1'b1;
         end
      end else if (pop_valid) begin
         case (pop_entry.op)
            OP_RETURN: begin
               pop       = 1'b1;
               column_in = '0;
            end
            OP_NEWLINE: begin
               if (out_free || !scroll) begin
                  pop       = 1'b1;
                  column_in = '0;
                  page_in   = page_wrapped[3:0];
                  if (scroll) begin
                     start_in     = start_wrapped[3:0];
                     rsp_valid_in = 1'b1;
                     kind_in      = CMD_SET_ROW;
                     col_out_in   = '0;
                     page_out_in  = '0;
                     glyph_out_in = '0;
                     row_out_in   = scroll_row;
                     last_in      = 1'b1;
                  end
               end
            end
            OP_GLYPH: begin
               if (drop) begin
                  pop = 1'b1;
               end else if (out_free) begin
                  pop          = 1'b1;
                  rsp_valid_in = 1'b1;
                  kind_in      = CMD_DRAW;
                  col_out_in   = column_ff;
                  page_out_in  = page_ff;
                  glyph_out_in = pop_entry.glyph;
                  row_out_in   = '0;
                  last_in      = !(wrap_nl && scroll);
                  column_in    = column_adv;
                  if (wrap_nl) begin
                     column_in = '0;
                     page_in   = page_wrapped[3:0];
                     if (scroll) begin
                        start_in    = start_wrapped[3:0];
                        pend_in     = 1'b1;
                        pend_row_in = scroll_row;
                     end
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         page_ff      <= '0;
         start_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         column_ff    <= column_in;
         page_ff      <= page_in;
         start_ff     <= start_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_row_ff  <= pend_row_in;
      kind_ff      <= kind_in;
      col_out_ff   <= col_out_in;
      page_out_ff  <= page_out_in;
      glyph_out_ff <= glyph_out_in;
      row_out_ff   <= row_out_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_kind = kind_ff;
   assign rsp_column_px    = col_out_ff;
   assign rsp_page_row     = page_out_ff;
   assign rsp_glyph_index  = glyph_out_ff;
   assign rsp_display_row  = row_out_ff;
   assign rsp_last_result  = last_ff;

   `TCSE_ASSERT(a_pend_behind_result, pend_ff |-> rsp_valid_ff, "scroll pending, no result")
   `TCSE_ASSERT(a_pend_not_last, pend_ff |-> !last_ff, "draw marked last while scroll pending")
   `TCSE_ASSERT(a_page_range, page_ff < MEM_4, "cursor page out of range")
   `TCSE_ASSERT(a_start_range, start_ff < MEM_4, "start page out of range")
   `TCSE_ASSERT_NEXT(a_pend_blocks_pop, pend_ff, !pend_ff || rsp_valid_ff, "pending scroll lost")

endmodule

`default_nettype wire

// ----- hdl/text_cursor_scroll_engine_top.sv -----
// A character transfer passes the front register, a queue slot and the result register.
// Throughput: one character per cycle while no stall holds the flow; a draw that wraps
// and scrolls holds the back end until both commands leave by the single result register.
// Reset (synchronous): clears cursor column, cursor page, start page, wrap_enable and queue.
// Depends on tcse_pkg, tcse_front, tcse_queue and tcse_back.
`timescale 1ns / 1ps
`default_nettype none

module text_cursor_scroll_engine_top #(
   parameter int SCREEN_WIDTH = tcse_pkg::SCREEN_WIDTH_DEF,
   parameter int VIEW_PAGES   = tcse_pkg::VIEW_PAGES_DEF,
   parameter int MEMORY_PAGES = tcse_pkg::MEMORY_PAGES_DEF,
   parameter int QUEUE_DEPTH  = tcse_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_command_kind,
   output logic [7:0]       rsp_column_px,
   output logic [3:0]       rsp_page_row,
   output logic [6:0]       rsp_glyph_index,
   output logic [6:0]       rsp_display_row,
   output logic             rsp_last_result,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tcse_pkg::*;

   logic      wrap_ff, wrap_in;
   logic      csr_write;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop;
   entry_type pop_entry;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      wrap_in = wrap_ff;
      if (csr_write && csr_paddr[2] == REG_WRAP_ENABLE) begin
         wrap_in = csr_pwdata[0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_WRAP_ENABLE) ? {31'b0, wrap_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wrap_ff <= 1'b0;
      end else begin
         wrap_ff <= wrap_in;
      end
   end

   tcse_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .push_valid    (push_valid),
      .push_entry    (push_entry),
      .push_ready    (push_ready)
   );

   tcse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   tcse_back #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .VIEW_PAGES   (VIEW_PAGES),
      .MEMORY_PAGES (MEMORY_PAGES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .wrap_enable      (wrap_ff),
      .pop_valid        (pop_valid),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command_kind (rsp_command_kind),
      .rsp_column_px    (rsp_column_px),
      .rsp_page_row     (rsp_page_row),
      .rsp_glyph_index  (rsp_glyph_index),
      .rsp_display_row  (rsp_display_row),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

`default_nettype wire
